// ===== sv/motor_feedback_decoder_defines.svh =====
// Assertion macros for the motor feedback decoder checker
`ifndef MOTOR_FEEDBACK_DECODER_DEFINES_SVH
`define MOTOR_FEEDBACK_DECODER_DEFINES_SVH

// checked outside reset only
`define MFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define MFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mfd_pkg.sv =====
// Types and constants shared by the motor feedback decoder
`default_nettype none
package mfd_pkg;

  localparam int POS_W        = 13;
  localparam int SUM_W        = 32;
  localparam int TICK_W       = 17;
  localparam int LIMIT_W      = 16;
  localparam int STEP_W       = 15;
  localparam int WRAP_LIMIT   = 4095;
  localparam int TURN_COUNTS  = 8192;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_OFFLINE_LIMIT = 1'b0;

  typedef struct packed {
    logic       func;
    logic [7:0] pos_hi;
    logic [7:0] pos_lo;
    logic [7:0] spd_hi;
    logic [7:0] spd_lo;
    logic [7:0] cur_hi;
    logic [7:0] cur_lo;
    logic [7:0] temp_byte;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic signed [15:0]      speed_rpm;
    logic signed [15:0]      current_code;
    logic [7:0]              temperature;
    logic signed [SUM_W-1:0] turn_sum;
    logic                    online;
  } out_item_t;

endpackage
`default_nettype wire

// ===== sv/mfd_cfg.sv =====
// APB register block holding the offline tick limit
`default_nettype none
module mfd_cfg
  import mfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic     [LIMIT_W-1:0] offline_limit
);

  logic reg_hit;

  assign reg_hit = (paddr[2] == REG_OFFLINE_LIMIT);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offline_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      offline_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(DATA_W-LIMIT_W){1'b0}}, offline_limit};
    end
  end

endmodule
`default_nettype wire

// ===== sv/mfd_unwrap.sv =====
// Multi-turn position unwrap: last position and accumulated sum
`default_nettype none
module mfd_unwrap
  import mfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [POS_W-1:0] pos,
  output logic      [POS_W-1:0] position_next,
  output logic      [SUM_W-1:0] sum_next
);

  logic [POS_W-1:0]  last_position;
  logic [SUM_W-1:0]  position_sum;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] add;

  always_comb begin
    if (last_position == '0 && position_sum == '0) begin
      step = '0;
    end else begin
      step = {2'b00, pos} - {2'b00, last_position};
    end
    if ($signed(step) > $signed(STEP_W'(WRAP_LIMIT))) begin
      add = step - STEP_W'(TURN_COUNTS);
    end else if ($signed(step) < -$signed(STEP_W'(WRAP_LIMIT))) begin
      add = step + STEP_W'(TURN_COUNTS);
    end else begin
      add = step;
    end
    if (take) begin
      position_next = pos;
      sum_next      = position_sum + {{(SUM_W-STEP_W){add[STEP_W-1]}}, add};
    end else begin
      position_next = last_position;
      sum_next      = position_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position <= '0;
      position_sum  <= '0;
    end else begin
      last_position <= position_next;
      position_sum  <= sum_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mfd_watchdog.sv =====
// Link watchdog: silent tick counter and online status
`default_nettype none
module mfd_watchdog
  import mfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               frame,
  input  wire logic               tick,
  input  wire logic [LIMIT_W-1:0] offline_limit,
  output logic                    link_next
);

  logic [TICK_W-1:0] silent_ticks;
  logic [TICK_W-1:0] silent_ticks_next;
  logic [TICK_W-1:0] count;
  logic              link_up;

  always_comb begin
    count             = silent_ticks + TICK_W'(1);
    silent_ticks_next = silent_ticks;
    link_next         = link_up;
    if (frame) begin
      silent_ticks_next = '0;
    end else if (tick) begin
      if (count > {1'b0, offline_limit}) begin
        silent_ticks_next = {1'b0, offline_limit};
        link_next         = 1'b0;
      end else begin
        silent_ticks_next = count;
        link_next         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silent_ticks <= '0;
      link_up      <= 1'b0;
    end else begin
      silent_ticks <= silent_ticks_next;
      link_up      <= link_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/motor_feedback_decoder.sv =====
// Motor feedback decoder top level: input register, update logic, result register
// An accepted item waits in the input register and moves to the result register
// when fb is not stalled. One item per cycle while fb is not stalled: the state
// update is one pass between those registers, so back-to-back items chain directly.
// Reset clears the sum, position, counter and held values, marks the link
// offline and loads the offline limit with 100.
`default_nettype none
module motor_feedback_decoder
  import mfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire in_item_t          item,
  output logic                   fb_valid,
  input  wire logic              fb_stall,
  output out_item_t              fb,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  in_item_t           in_reg;
  logic               in_full;
  logic               advance;
  logic               take_frame;
  logic               take_tick;
  logic [LIMIT_W-1:0] offline_limit;
  logic [POS_W-1:0]   position_next;
  logic [SUM_W-1:0]   sum_next;
  logic               link_next;
  logic [15:0]        held_speed;
  logic [15:0]        held_current;
  logic [7:0]         held_temperature;
  logic [15:0]        speed_next;
  logic [15:0]        current_next;
  logic [7:0]         temperature_next;

  assign advance    = in_full && (!fb_valid || !fb_stall);
  assign item_stall = in_full && !advance;
  assign take_frame = advance && (in_reg.func == FUNC_FRAME);
  assign take_tick  = advance && (in_reg.func == FUNC_TICK);

  mfd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .offline_limit (offline_limit)
  );

  mfd_unwrap u_unwrap (
    .clk           (clk),
    .rst           (rst),
    .take          (take_frame),
    .pos           ({in_reg.pos_hi[4:0], in_reg.pos_lo}),
    .position_next (position_next),
    .sum_next      (sum_next)
  );

  mfd_watchdog u_watchdog (
    .clk           (clk),
    .rst           (rst),
    .frame         (take_frame),
    .tick          (take_tick),
    .offline_limit (offline_limit),
    .link_next     (link_next)
  );

  always_comb begin
    speed_next       = held_speed;
    current_next     = held_current;
    temperature_next = held_temperature;
    if (take_frame) begin
      speed_next       = {in_reg.spd_hi, in_reg.spd_lo};
      current_next     = {in_reg.cur_hi, in_reg.cur_lo};
      temperature_next = in_reg.temp_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full          <= 1'b0;
      fb_valid         <= 1'b0;
      held_speed       <= '0;
      held_current     <= '0;
      held_temperature <= '0;
    end else begin
      if (item_valid && !item_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        fb_valid <= 1'b1;
      end else if (!fb_stall) begin
        fb_valid <= 1'b0;
      end
      held_speed       <= speed_next;
      held_current     <= current_next;
      held_temperature <= temperature_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_reg <= item;
    end
    if (advance) begin
      fb.position     <= position_next;
      fb.speed_rpm    <= $signed(speed_next);
      fb.current_code <= $signed(current_next);
      fb.temperature  <= temperature_next;
      fb.turn_sum     <= $signed(sum_next);
      fb.online       <= link_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mfd_checker.sv =====
// Port-level checker for the motor feedback decoder, bound to the top level
`default_nettype none
`include "motor_feedback_decoder_defines.svh"
module mfd_checker
  import mfd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      item_valid,
  input wire logic      item_stall,
  input wire logic      fb_valid,
  input wire logic      fb_stall,
  input wire out_item_t fb
);

  `MFD_ASSERT_ALWAYS(a_reset_empty, rst |=> !fb_valid, "result valid after reset")
  `MFD_ASSERT(a_stall_cause, item_stall |-> (fb_valid && fb_stall), "stall without backpressure")
  `MFD_ASSERT(a_result_hold, (fb_valid && fb_stall) |=> (fb_valid && $stable(fb)), "held beat moved")
  `MFD_ASSERT(a_flow, (item_valid && !item_stall) |=> ##1 fb_valid, "beat produced no result")

endmodule

bind motor_feedback_decoder mfd_checker u_mfd_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .fb_valid   (fb_valid),
  .fb_stall   (fb_stall),
  .fb         (fb)
);
`default_nettype wire
